// ----- rtl/qea_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package qea_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned WinW   = 8;

  localparam logic [1:0]      PhaseReset  = 2'b11;
  localparam logic [WinW-1:0] WindowReset = 8'd27;
  localparam logic [WinW-1:0] JumpBase    = 8'd10;
  localparam logic signed [3:0] AccumHigh = 4'sd3;
  localparam logic signed [3:0] AccumLow  = -4'sd3;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic {
    REG_ACCEL_ENABLE = 1'b0,
    REG_ACCEL_WINDOW = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]               op;
    logic                     phase_a;
    logic                     phase_b;
    logic                     button_level;
    logic [TimeW-1:0]         now_ms;
    logic signed [CountW-1:0] set_value;
  } item_t;

  typedef struct packed {
    logic signed [CountW-1:0] count;
    logic                     changed;
    logic                     button_released;
  } result_t;

  function automatic logic signed [3:0] step_lut(input logic [3:0] idx);
    logic signed [3:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  s = -4'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 4'sd1;
      default:                  s = 4'sd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/qea_in_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qea_in_reg import qea_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire item_t item_i,
  output logic       valid_o,
  input  wire logic  take_i,
  output item_t      item_o
);

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/qea_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qea_core import qea_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_idx_i,
  input  wire logic [WinW-1:0] cfg_wdata_i,
  input  wire logic            fire_i,
  input  wire item_t           item_i,
  output result_t              result_o
);

  logic                     accel_en_q;
  logic [WinW-1:0]          window_q;
  logic [1:0]               prev_phase_q, prev_phase_d;
  logic signed [3:0]        accum_q, accum_d;
  logic signed [CountW-1:0] count_q, count_d;
  logic signed [CountW-1:0] prior_q, prior_d;
  logic [TimeW-1:0]         last_q, last_d;
  logic                     pressed_q, pressed_d;

  logic [1:0]               cur;
  logic signed [3:0]        acc_sum;
  logic signed [CountW-1:0] cnt_step;
  logic signed [CountW-1:0] cnt_acc;
  logic [TimeW-1:0]         elapsed;
  logic                     moved;
  logic                     in_win;
  logic [WinW-1:0]          jump;
  logic                     pressed;

  always_comb begin
    cur     = {item_i.phase_a, item_i.phase_b};
    acc_sum = accum_q + step_lut({prev_phase_q, cur});
    if (acc_sum > AccumHigh) begin
      cnt_step = count_q - 32'sd1;
    end else if (acc_sum < AccumLow) begin
      cnt_step = count_q + 32'sd1;
    end else begin
      cnt_step = count_q;
    end
    moved   = prior_q != cnt_step;
    elapsed = item_i.now_ms - last_q;
    in_win  = elapsed < {{(TimeW-WinW){1'b0}}, window_q};
    jump    = JumpBase ^ (window_q - elapsed[WinW-1:0]);
    if (prior_q > cnt_step) begin
      cnt_acc = cnt_step - $signed({{(CountW-WinW){1'b0}}, jump});
    end else begin
      cnt_acc = cnt_step + $signed({{(CountW-WinW){1'b0}}, jump});
    end
    pressed = !item_i.button_level;

    prev_phase_d = prev_phase_q;
    accum_d      = accum_q;
    count_d      = count_q;
    prior_d      = prior_q;
    last_d       = last_q;
    pressed_d    = pressed_q;
    result_o.changed         = 1'b0;
    result_o.button_released = 1'b0;

    case (item_i.op)
      OP_SAMPLE: begin
        prev_phase_d = cur;
        accum_d      = (acc_sum > AccumHigh || acc_sum < AccumLow) ? 4'sd0 : acc_sum;
        count_d      = (moved && accel_en_q && in_win) ? cnt_acc : cnt_step;
        prior_d      = count_d;
        if (moved) begin
          last_d = item_i.now_ms;
        end
        pressed_d = pressed;
        result_o.changed         = moved;
        result_o.button_released = !pressed && pressed_q;
      end
      OP_LOAD: begin
        count_d = item_i.set_value;
      end
      OP_CLEAR: begin
        count_d = '0;
        prior_d = '0;
        last_d  = item_i.now_ms;
      end
      default: begin
      end
    endcase
    result_o.count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_en_q   <= 1'b0;
      window_q     <= WindowReset;
      prev_phase_q <= PhaseReset;
      accum_q      <= '0;
      count_q      <= '0;
      prior_q      <= '0;
      last_q       <= '0;
      pressed_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_ACCEL_ENABLE: accel_en_q <= cfg_wdata_i[0];
          REG_ACCEL_WINDOW: window_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (fire_i) begin
        prev_phase_q <= prev_phase_d;
        accum_q      <= accum_d;
        count_q      <= count_d;
        prior_q      <= prior_d;
        last_q       <= last_d;
        pressed_q    <= pressed_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/qea_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qea_out_reg import qea_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         ready_o,
  input  wire result_t result_i,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      result_o
);

  logic    valid_q;
  result_t result_q;

  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/quadrature_encoder_with_acceleration_unit.sv -----
// An input transfer is captured in the input register, decoded by the core and
// held in the result register before it appears on the output.
// Throughput: one item per cycle unless out_ready_i stalls the output; the count
// state updates in the single decode pass between input and result registers.
// Reset: rst_ni asynchronous, active low; clears both stages, the count state
// and sets accel_enable to 0 and accel_window_ms to 27.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_encoder_with_acceleration_unit import qea_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_idx_i,
  input  wire logic [WinW-1:0]          cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [1:0]               op_i,
  input  wire logic                     phase_a_i,
  input  wire logic                     phase_b_i,
  input  wire logic                     button_level_i,
  input  wire logic [TimeW-1:0]         now_ms_i,
  input  wire logic signed [CountW-1:0] set_value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [CountW-1:0]      count_o,
  output logic                          changed_o,
  output logic                          button_released_o
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    s2_ready;
  result_t core_res;
  result_t out_res;

  assign in_item = '{op: op_i, phase_a: phase_a_i, phase_b: phase_b_i,
                     button_level: button_level_i, now_ms: now_ms_i,
                     set_value: set_value_i};

  qea_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .valid_o (s1_valid),
    .take_i  (s2_ready),
    .item_o  (s1_item)
  );

  qea_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (s1_valid && s2_ready),
    .item_i      (s1_item),
    .result_o    (core_res)
  );

  qea_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .ready_o  (s2_ready),
    .result_i (core_res),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (out_res)
  );

  assign count_o           = out_res.count;
  assign changed_o         = out_res.changed;
  assign button_released_o = out_res.button_released;

endmodule

`default_nettype wire

// ----- rtl/qea_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qea_checker import qea_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_ready_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic signed [CountW-1:0] count_o,
  input wire logic                     button_released_o
);

  logic last_rel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_rel_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      last_rel_q <= button_released_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(count_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_release_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && button_released_o |-> !last_rel_q)
    else $error("two release pulses in a row");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind quadrature_encoder_with_acceleration_unit qea_checker u_qea_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .count_o           (count_o),
  .button_released_o (button_released_o)
);

`default_nettype wire
